// ===== design/seven_segment_number_display_sequencer_macros.svh =====
// assertion macros for the seven-segment display sequencer
// included by the modules that carry concurrent checks; no other dependencies
`ifndef SEVEN_SEGMENT_NUMBER_DISPLAY_SEQUENCER_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_DISPLAY_SEQUENCER_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("implication check failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
// condition never holds
`define ASSERT_NEVER(label, ck, rn, cond) \
	label: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, ck, rn, ante, cons)
`define ASSERT_NEXT(label, ck, rn, ante, cons)
`define ASSERT_NEVER(label, ck, rn, cond)
`endif
`endif

// ===== design/ssnds_pkg.sv =====
// shared types, constants and glyph lookup for the display sequencer
// no dependencies; imported by every module of the block
package ssnds_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int GLYPH_COUNT = 34;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] BLANK_INDEX  = 8'h20;
	localparam logic [7:0] MINUS_INDEX  = 8'h21;
	localparam logic [7:0] ERROR_INDEX  = 8'h0e;
	localparam logic [7:0] POINT_OFFSET = 8'h10;

	// request kinds
	typedef enum logic [1:0] {
		OP_NUMBER = 2'd0,
		OP_CODES  = 2'd1,
		OP_DIGIT  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// configuration register file
	typedef struct packed {
		logic [2:0] brightness;
		logic [7:0] display_on_base;
		logic [7:0] auto_increment_cmd;
		logic [7:0] fixed_address_cmd;
		logic [7:0] start_address_cmd;
		logic [7:0] set_address_cmd;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		brightness:         3'd2,
		display_on_base:    8'h88,
		auto_increment_cmd: 8'h40,
		fixed_address_cmd:  8'h44,
		start_address_cmd:  8'hc0,
		set_address_cmd:    8'hc0
	};

	// one classified request in the queue; idx[0] is the leftmost digit
	typedef struct packed {
		logic                             single;
		logic [2:0]                       position;
		logic [DIGIT_COUNT-1:0][7:0]      idx;
	} entry_t;

	// segment patterns: 0-9, A-F, dotted 0-9, dotted A-F, blank, minus
	localparam logic [7:0] GLYPH_TABLE [GLYPH_COUNT] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
		8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71,
		8'hbf, 8'h86, 8'hdb, 8'hcf, 8'he6, 8'hed, 8'hfd, 8'h87, 8'hff, 8'hef,
		8'hf7, 8'hfc, 8'hb9, 8'hde, 8'hf9, 8'hf1,
		8'h00, 8'h40
	};

	// index past the table end shows blank
	function automatic logic [7:0] glyph_of(input logic [7:0] idx);
		logic [5:0] sel;
		sel = (idx < 8'(GLYPH_COUNT)) ? idx[5:0] : BLANK_INDEX[5:0];
		return GLYPH_TABLE[sel];
	endfunction

endpackage

// ===== design/ssnds_front.sv =====
// front end: accepts requests, classifies them and formats op 0 numbers
// depends on ssnds_pkg; feeds entries into ssnds_queue
module ssnds_front
	import ssnds_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] number,
	input  logic [2:0]         decimals,
	input  logic [7:0]         code_a,
	input  logic [7:0]         code_b,
	input  logic [7:0]         code_c,
	input  logic [7:0]         code_d,
	input  logic [2:0]         position,
	input  logic [7:0]         digit_char,
	input  logic               dp_en,
	output logic               push,
	output entry_t             push_entry,
	input  logic               full
);

	localparam int TW         = FRACTION_BITS + 15;
	localparam int PW         = FRACTION_BITS + 39;
	localparam int RW         = 37;
	localparam int BCD_DIGITS = 11;
	localparam int CW         = $clog2(RW);
	localparam logic [PW-1:0] HALF    = PW'(1) << FRACTION_BITS;
	localparam logic [39:0]   LIM_POS = 40'(19999) << FRACTION_BITS;
	localparam logic [39:0]   LIM_NEG = 40'(1999) << FRACTION_BITS;
	localparam logic [7:0] UPPER_A    = 8'h41;
	localparam logic [7:0] UPPER_F    = 8'h46;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_F    = 8'h66;
	localparam logic [7:0] UPPER_BIAS = 8'h37;
	localparam logic [7:0] LOWER_BIAS = 8'h57;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CONV,
		ST_EVAL,
		ST_PUSH
	} state_t;

	state_t                         state_q;
	logic                           neg_q;
	logic [TW-1:0]                  twom_q;
	logic [PW-1:0]                  prod_q;
	logic [2:0]                     dec_q;
	logic [2:0]                     mcnt_q;
	logic [RW-1:0]                  sr_q;
	logic [BCD_DIGITS-1:0][3:0]     bcd_q;
	logic [CW-1:0]                  cnt_q;
	entry_t                         entry_q;

	logic                           neg_in;
	logic [31:0]                    mag_in;
	logic [32:0]                    twom_in;
	logic [TW-1:0]                  twom_trunc;
	logic                           range_err;
	logic                           take;
	logic [7:0]                     ch_idx;
	entry_t                         direct_entry;
	entry_t                         err_entry;
	logic [PW-1:0]                  prod_x10;
	logic [RW-1:0]                  rounded;
	logic [BCD_DIGITS-1:0][3:0]     bcd_adj;
	logic [4*BCD_DIGITS-1:0]        bcd_flat;
	logic [DIGIT_COUNT-1:0][3:0]    int_dig;
	logic [2:0]                     n_dig;
	logic [2:0]                     lead;
	logic [3:0]                     total;
	logic [3:0]                     span;
	logic                           redo;
	logic [2:0]                     dec_new;
	entry_t                         num_entry;

	// magnitude, doubled, and range check
	assign neg_in     = number[31];
	assign mag_in     = neg_in ? (~number + 32'd1) : number;
	assign twom_in    = {mag_in, 1'b0};
	assign twom_trunc = TW'(twom_in);
	assign range_err  = neg_in ? (40'(twom_in) >= LIM_NEG) : (40'(twom_in) >= LIM_POS);

	assign in_ready = (state_q == ST_IDLE) && !full;
	assign take     = in_valid && in_ready;

	// op 1 and op 2 classification
	always_comb begin
		ch_idx = digit_char;
		if (digit_char inside {[UPPER_A:UPPER_F]}) begin
			ch_idx = digit_char - UPPER_BIAS;
		end else if (digit_char inside {[LOWER_A:LOWER_F]}) begin
			ch_idx = digit_char - LOWER_BIAS;
		end
		if (dp_en) begin
			ch_idx = ch_idx + POINT_OFFSET;
		end
		direct_entry.single   = (op == OP_DIGIT);
		direct_entry.position = position;
		if (op == OP_DIGIT) begin
			direct_entry.idx = {BLANK_INDEX, BLANK_INDEX, BLANK_INDEX, ch_idx};
		end else begin
			direct_entry.idx = {code_d, code_c, code_b, code_a};
		end
	end

	// out of range: blank, blank, blank, E
	always_comb begin
		err_entry          = '0;
		err_entry.single   = 1'b0;
		for (int j = 0; j < DIGIT_COUNT; j++) begin
			err_entry.idx[j] = BLANK_INDEX;
		end
		err_entry.idx[DIGIT_COUNT-1] = ERROR_INDEX;
	end

	// scale by ten and round
	assign prod_x10 = (prod_q << 3) + (prod_q << 1);
	assign rounded  = RW'((prod_q + HALF) >> (FRACTION_BITS + 1));

	// binary to bcd, one bit per cycle
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		bcd_flat = bcd_adj;
	end

	// digit count, width check and right-justified layout
	always_comb begin
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			int_dig[k] = bcd_q[4'(dec_q) + 4'(k)];
		end
		if (int_dig[3] != 4'd0) begin
			n_dig = 3'd4;
		end else if (int_dig[2] != 4'd0) begin
			n_dig = 3'd3;
		end else if (int_dig[1] != 4'd0) begin
			n_dig = 3'd2;
		end else begin
			n_dig = 3'd1;
		end
		lead    = 3'(neg_q) + n_dig;
		total   = 4'(lead) + 4'(dec_q);
		span    = 4'(n_dig) + 4'(dec_q);
		redo    = (total > 4'(DIGIT_COUNT)) && (dec_q != 3'd0);
		dec_new = (lead >= 3'(DIGIT_COUNT)) ? 3'd0 : (3'(DIGIT_COUNT) - lead);
		num_entry          = '0;
		num_entry.single   = 1'b0;
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			if (4'(k) < span) begin
				num_entry.idx[DIGIT_COUNT-1-k] = {4'h0, bcd_q[k]};
				if ((4'(k) == 4'(dec_q)) && (dec_q != 3'd0)) begin
					num_entry.idx[DIGIT_COUNT-1-k] = {4'h0, bcd_q[k]} | POINT_OFFSET;
				end
			end else if ((4'(k) == span) && neg_q) begin
				num_entry.idx[DIGIT_COUNT-1-k] = MINUS_INDEX;
			end else begin
				num_entry.idx[DIGIT_COUNT-1-k] = BLANK_INDEX;
			end
		end
	end

	// queue write
	assign push = (take && ((op == OP_CODES) || (op == OP_DIGIT)))
		|| ((state_q == ST_PUSH) && !full);
	assign push_entry = (state_q == ST_PUSH) ? entry_q : direct_entry;

	// formatter sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mcnt_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take && (op == OP_NUMBER)) begin
						neg_q  <= neg_in;
						twom_q <= twom_trunc;
						prod_q <= PW'(twom_trunc);
						dec_q  <= decimals;
						mcnt_q <= decimals;
						if (range_err) begin
							entry_q <= err_entry;
							state_q <= ST_PUSH;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (mcnt_q == 3'd0) begin
						sr_q    <= rounded;
						bcd_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end else begin
						prod_q <= prod_x10;
						mcnt_q <= mcnt_q - 3'd1;
					end
				end
				ST_CONV: begin
					bcd_q <= {bcd_flat[4*BCD_DIGITS-2:0], sr_q[RW-1]};
					sr_q  <= sr_q << 1;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(RW - 1)) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (redo) begin
						dec_q   <= dec_new;
						mcnt_q  <= dec_new;
						prod_q  <= PW'(twom_q);
						state_q <= ST_MUL;
					end else begin
						entry_q <= num_entry;
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/ssnds_queue.sv =====
// short request queue between the front end and the byte sequencer
// depends on ssnds_pkg and the assertion macro header
`include "seven_segment_number_display_sequencer_macros.svh"
module ssnds_queue
	import ssnds_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t pop_entry,
	output logic   empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full)
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty)
	`ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + CNT_W'(1))

endmodule

// ===== design/ssnds_back.sv =====
// back end: walks one queued request and emits its command bytes in order
// depends on ssnds_pkg and the assertion macro header
`include "seven_segment_number_display_sequencer_macros.svh"
module ssnds_back
	import ssnds_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_empty,
	input  entry_t     q_entry,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       start_before,
	output logic       stop_after,
	output logic       last
);

	localparam int GSEL_W = $clog2(DIGIT_COUNT);
	localparam logic [2:0] STEP_CMD         = 3'd0;
	localparam logic [2:0] STEP_ADDR        = 3'd1;
	localparam logic [2:0] STEP_GLYPH       = 3'd2;
	localparam logic [2:0] STEP_SINGLE_CTRL = 3'd3;
	localparam logic [2:0] STEP_GLYPH_LAST  = 3'(2 + DIGIT_COUNT - 1);
	localparam logic [2:0] STEP_BURST_CTRL  = 3'(2 + DIGIT_COUNT);

	logic        busy_q;
	entry_t      cur_q;
	logic [2:0]  step_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_start_q;
	logic        out_stop_q;
	logic        out_last_q;

	logic        out_free;
	logic        load;
	logic [7:0]  control;
	logic [GSEL_W-1:0] gsel;
	logic [7:0]  nb_byte;
	logic        nb_start;
	logic        nb_stop;
	logic        nb_last;

	assign out_free = !out_valid_q || out_ready;
	assign load     = busy_q && out_free;
	assign q_pop    = !busy_q && !q_empty;
	assign control  = cfg.display_on_base + 8'(cfg.brightness);
	assign gsel     = GSEL_W'(step_q - STEP_GLYPH);

	// next byte of the current request
	always_comb begin
		nb_byte  = control;
		nb_start = 1'b1;
		nb_stop  = 1'b1;
		nb_last  = 1'b0;
		if (cur_q.single) begin
			case (step_q)
				STEP_CMD: begin
					nb_byte = cfg.fixed_address_cmd;
				end
				STEP_ADDR: begin
					nb_byte = cfg.start_address_cmd | {5'b0, cur_q.position};
					nb_stop = 1'b0;
				end
				STEP_GLYPH: begin
					nb_byte  = glyph_of(cur_q.idx[0]);
					nb_start = 1'b0;
				end
				STEP_SINGLE_CTRL: begin
					nb_last = 1'b1;
				end
				default: begin
					nb_last = 1'b1;
				end
			endcase
		end else begin
			case (step_q)
				STEP_CMD: begin
					nb_byte = cfg.auto_increment_cmd;
				end
				STEP_ADDR: begin
					nb_byte = cfg.set_address_cmd;
					nb_stop = 1'b0;
				end
				STEP_BURST_CTRL: begin
					nb_last = 1'b1;
				end
				default: begin
					nb_byte  = glyph_of(cur_q.idx[gsel]);
					nb_start = 1'b0;
					nb_stop  = (step_q == STEP_GLYPH_LAST);
				end
			endcase
		end
	end

	// request walker and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_CMD;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_q  <= q_entry;
				busy_q <= 1'b1;
				step_q <= STEP_CMD;
			end
			if (load) begin
				out_byte_q  <= nb_byte;
				out_start_q <= nb_start;
				out_stop_q  <= nb_stop;
				out_last_q  <= nb_last;
				step_q      <= step_q + 3'd1;
				if (nb_last) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign start_before = out_start_q;
	assign stop_after   = out_stop_q;
	assign last         = out_last_q;

	`ASSERT_IMPLIES(a_last_framed, clk, arst_n, out_valid_q && out_last_q, out_start_q && out_stop_q)
	`ASSERT_IMPLIES(a_busy_ends_on_last, clk, arst_n, $fell(busy_q), $past(load && nb_last))
	`ASSERT_NEXT(a_pop_starts_walk, clk, arst_n, q_pop, busy_q && (step_q == STEP_CMD))

endmodule

// ===== design/seven_segment_number_display_sequencer.sv =====
// top level of the seven-segment display command sequencer
// depends on ssnds_pkg, ssnds_front, ssnds_queue and ssnds_back
//
// channel   direction  carries
// s_axis    in         one request: op in tuser, operands in tdata
// m_axis    out        one command byte, start/stop marks in tuser, tlast on final byte
// cfg       in         register write: cfg_addr selects, cfg_data holds the value
//
// op 1 and op 2 requests are classified and queued as soon as they are taken; op 3 is dropped.
// op 0 runs per formatting pass one multiply by ten per decimal, rounding, a 37-bit bcd
// conversion and a width check that may cut the decimals; up to three passes.
// the byte sequencer pops a request when idle, then sends 7 bytes (4 for op 2)
// at one byte per cycle while m_axis_tready.
// reset clears all control state and loads the register defaults; cfg_ready is always high.
module seven_segment_number_display_sequencer
	import ssnds_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// number[31:0], decimals[34:32], code_a[42:35], code_b[50:43], code_c[58:51],
	// code_d[66:59], position[69:67], digit_char[77:70], dp_en[78], zero[79]
	input  logic [79:0] s_axis_tdata,
	// op[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_byte[7:0]
	output logic [7:0]  m_axis_tdata,
	// start_before[0], stop_after[1]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [7:0]  cfg_data
);

	typedef enum logic [2:0] {
		REG_BRIGHTNESS      = 3'd0,
		REG_DISPLAY_ON_BASE = 3'd1,
		REG_AUTO_INC        = 3'd2,
		REG_FIXED_ADDR      = 3'd3,
		REG_START_ADDR      = 3'd4,
		REG_SET_ADDR        = 3'd5
	} reg_idx_t;

	cfg_t        cfg_q;
	logic        push;
	entry_t      push_entry;
	logic        full;
	logic        pop;
	entry_t      pop_entry;
	logic        empty;
	logic        start_before;
	logic        stop_after;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_BRIGHTNESS:      cfg_q.brightness         <= cfg_data[2:0];
				REG_DISPLAY_ON_BASE: cfg_q.display_on_base    <= cfg_data;
				REG_AUTO_INC:        cfg_q.auto_increment_cmd <= cfg_data;
				REG_FIXED_ADDR:      cfg_q.fixed_address_cmd  <= cfg_data;
				REG_START_ADDR:      cfg_q.start_address_cmd  <= cfg_data;
				REG_SET_ADDR:        cfg_q.set_address_cmd    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// request intake and number formatting
	ssnds_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.op         (s_axis_tuser),
		.number     ($signed(s_axis_tdata[31:0])),
		.decimals   (s_axis_tdata[34:32]),
		.code_a     (s_axis_tdata[42:35]),
		.code_b     (s_axis_tdata[50:43]),
		.code_c     (s_axis_tdata[58:51]),
		.code_d     (s_axis_tdata[66:59]),
		.position   (s_axis_tdata[69:67]),
		.digit_char (s_axis_tdata[77:70]),
		.dp_en      (s_axis_tdata[78]),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	// decoupling queue
	ssnds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	// byte sequencer
	ssnds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (empty),
		.q_entry      (pop_entry),
		.q_pop        (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_byte     (m_axis_tdata),
		.start_before (start_before),
		.stop_after   (stop_after),
		.last         (m_axis_tlast)
	);

	assign m_axis_tuser = {stop_after, start_before};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for the seven-segment display command sequencer
// needs ssnds_pkg and the sequencer rtl; predicts every command byte and checks it in order

import ssnds_pkg::*;

// register indexes on the configuration channel
typedef enum logic [2:0] {
	REG_BRIGHTNESS      = 3'd0,
	REG_DISPLAY_ON_BASE = 3'd1,
	REG_AUTO_INCREMENT  = 3'd2,
	REG_FIXED_ADDRESS   = 3'd3,
	REG_START_ADDRESS   = 3'd4,
	REG_SET_ADDRESS     = 3'd5,
	REG_SPARE_6         = 3'd6,
	REG_SPARE_7         = 3'd7
} reg_index_t;

// one display request as it travels on the input stream
typedef struct packed {
	op_t         op;
	logic [31:0] number;
	logic [2:0]  decimals;
	logic [7:0]  code_a;
	logic [7:0]  code_b;
	logic [7:0]  code_c;
	logic [7:0]  code_d;
	logic [2:0]  position;
	logic [7:0]  digit_char;
	logic        dp_en;
} request_t;

// one byte bound for the display chip with its bus marks
typedef struct packed {
	logic [7:0] data;
	logic       start_before;
	logic       stop_after;
	logic       last;
} command_byte_t;

// glyph indexes of the four digits, element 0 is the leftmost
typedef logic [DIGIT_COUNT-1:0][7:0] digit_row_t;

class display_scoreboard #(int FRACTION_BITS = 16);
	cfg_t          regs;
	command_byte_t pending_bytes [$];
	int            errors;

	function new();
		regs   = CFG_RESET;
		errors = 0;
	endfunction

	// register write taken by the block
	function void write_register(reg_index_t index, logic [7:0] value);
		case (index)
			REG_BRIGHTNESS:      regs.brightness = value[2:0];
			REG_DISPLAY_ON_BASE: regs.display_on_base = value;
			REG_AUTO_INCREMENT:  regs.auto_increment_cmd = value;
			REG_FIXED_ADDRESS:   regs.fixed_address_cmd = value;
			REG_START_ADDRESS:   regs.start_address_cmd = value;
			REG_SET_ADDRESS:     regs.set_address_cmd = value;
			default: ;
		endcase
	endfunction

	function longint unsigned ten_to(int unsigned k);
		longint unsigned p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	// segment pattern, indexes past the table show blank
	function logic [7:0] segments(logic [7:0] index);
		if (index < 8'(GLYPH_COUNT))
			return GLYPH_TABLE[index[5:0]];
		return GLYPH_TABLE[BLANK_INDEX[5:0]];
	endfunction

	// fixed-point value to four glyph indexes: round half up, shrink decimals to fit
	function digit_row_t number_digits(logic [31:0] raw, logic [2:0] decimals);
		int unsigned     neg, d, n, total, b, i;
		longint unsigned mag, twom, scale, r, ip, fr;
		logic [7:0]      tmp [6];
		digit_row_t      idx;
		bit              done;
		neg  = raw[31];
		mag  = (neg != 0) ? ((64'd1 << 32) - 64'(raw)) : 64'(raw);
		twom = mag << 1;
		d    = decimals;
		fr   = 0;
		n    = 0;
		total = 0;
		for (i = 0; i < DIGIT_COUNT; i++)
			idx[i] = BLANK_INDEX;
		// at or past 9999.5 / -999.5 the display shows an error mark
		if ((neg == 0 && twom >= (64'd19999 << FRACTION_BITS)) ||
				(neg != 0 && twom >= (64'd1999 << FRACTION_BITS))) begin
			idx[DIGIT_COUNT-1] = ERROR_INDEX;
			return idx;
		end
		done = 1'b0;
		while (!done) begin
			scale = ten_to(d);
			r  = (twom * scale + (64'd1 << FRACTION_BITS)) >> (FRACTION_BITS + 1);
			ip = r / scale;
			fr = r % scale;
			n  = 0;
			do begin
				tmp[n] = 8'(ip % 10);
				n++;
				ip = ip / 10;
			end while (ip != 0 && n < 6);
			total = neg + n + d;
			if (total <= DIGIT_COUNT || d == 0)
				done = 1'b1;
			else
				d = (neg + n >= DIGIT_COUNT) ? 0 : DIGIT_COUNT - (neg + n);
		end
		// right-justify: sign, integer digits, point on last integer digit, decimals
		b = (total <= DIGIT_COUNT) ? DIGIT_COUNT - total : 0;
		if (neg != 0 && b < DIGIT_COUNT) begin
			idx[b] = MINUS_INDEX;
			b++;
		end
		for (i = n; i > 0; i--)
			if (b < DIGIT_COUNT) begin
				idx[b] = tmp[i-1];
				b++;
			end
		if (d > 0) begin
			if (b >= 1)
				idx[b-1] = idx[b-1] + POINT_OFFSET;
			for (i = d; i > 0; i--)
				if (b < DIGIT_COUNT) begin
					idx[b] = 8'((fr / ten_to(i - 1)) % 10);
					b++;
				end
		end
		return idx;
	endfunction

	function void push_byte(logic [7:0] data, logic start_before, logic stop_after,
			logic last);
		pending_bytes.push_back('{data, start_before, stop_after, last});
	endfunction

	// request taken by the block: queue the bytes it must send
	function void note_request(request_t r);
		logic [7:0] control;
		logic [7:0] ch;
		digit_row_t row;
		control = regs.display_on_base + {5'b0, regs.brightness};
		case (r.op)
			OP_NUMBER, OP_CODES: begin
				if (r.op == OP_NUMBER)
					row = number_digits(r.number, r.decimals);
				else
					row = {r.code_d, r.code_c, r.code_b, r.code_a};
				push_byte(regs.auto_increment_cmd, 1'b1, 1'b1, 1'b0);
				push_byte(regs.set_address_cmd, 1'b1, 1'b0, 1'b0);
				for (int i = 0; i < DIGIT_COUNT; i++)
					push_byte(segments(row[i]), 1'b0, i == DIGIT_COUNT - 1, 1'b0);
				push_byte(control, 1'b1, 1'b1, 1'b1);
			end
			OP_DIGIT: begin
				ch = r.digit_char;
				// hex letters in either case map to 10..15
				if (ch >= "A" && ch <= "F")
					ch = ch - "A" + 8'd10;
				else if (ch >= "a" && ch <= "f")
					ch = ch - "a" + 8'd10;
				if (r.dp_en)
					ch = ch + POINT_OFFSET;
				push_byte(regs.fixed_address_cmd, 1'b1, 1'b1, 1'b0);
				push_byte({5'b0, r.position} | regs.start_address_cmd, 1'b1, 1'b0, 1'b0);
				push_byte(segments(ch), 1'b0, 1'b1, 1'b0);
				push_byte(control, 1'b1, 1'b1, 1'b1);
			end
			default: ;
		endcase
	endfunction

	// byte taken from the block, compared against the oldest prediction
	function void check_byte(command_byte_t got);
		command_byte_t want;
		if (pending_bytes.size() == 0) begin
			errors++;
			$display("%0t: unexpected byte %h start %b stop %b last %b", $time,
				got.data, got.start_before, got.stop_after, got.last);
		end else begin
			want = pending_bytes.pop_front();
			if (got != want) begin
				errors++;
				$display("%0t: byte mismatch expected %h s%b p%b l%b actual %h s%b p%b l%b",
					$time, want.data, want.start_before, want.stop_after, want.last,
					got.data, got.start_before, got.stop_after, got.last);
			end
		end
	endfunction
endclass

module tb_top;
	localparam int FRAC_BITS       = 16;
	localparam int IDLE_LIMIT      = 2000;
	localparam int DRAIN_CYCLES    = 200;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_COUNT     = 5;
	localparam int PHASE_REQUESTS  = 70;

	// q15.16 values at the edges of the displayable range
	localparam logic [31:0] Q_TOP_BOUND    = 32'h270f_8000;  // 9999.5
	localparam logic [31:0] Q_BOTTOM_BOUND = 32'hfc18_8000;  // -999.5
	localparam logic [31:0] Q_NEAR_1000    = 32'h03e7_f333;  // 999.95
	localparam logic [31:0] Q_NEAR_100     = 32'h0063_feb8;  // 99.995

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// number, decimals, code_a..code_d, position, digit_char, dp_en, zero pad
	logic [79:0] s_axis_tdata = '0;
	// op
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// out_byte
	logic [7:0]  m_axis_tdata;
	// start_before, stop_after
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_addr = '0;
	logic [7:0]  cfg_data = '0;

	display_scoreboard #(FRAC_BITS) sb;
	int unsigned burst_left;
	int unsigned idle_cycles = 0;
	bit          hold_off_request = 1'b0;
	bit          hold_off_done = 1'b0;

	seven_segment_number_display_sequencer #(.FRACTION_BITS(FRAC_BITS)) i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one request, then maybe end the burst with a gap
	task automatic send_request(input request_t r);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.op;
		s_axis_tdata  <= {1'b0, r.dp_en, r.digit_char, r.position, r.code_d, r.code_c,
			r.code_b, r.code_a, r.decimals, r.number};
		do @(negedge clk); while (!s_axis_tready);
		sb.note_request(r);
		@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 19);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_number(input logic [31:0] number, input logic [2:0] decimals);
		request_t r;
		r          = '0;
		r.op       = OP_NUMBER;
		r.number   = number;
		r.decimals = decimals;
		send_request(r);
	endtask

	task automatic send_codes(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
			input logic [7:0] d);
		request_t r;
		r        = '0;
		r.op     = OP_CODES;
		r.code_a = a;
		r.code_b = b;
		r.code_c = c;
		r.code_d = d;
		send_request(r);
	endtask

	task automatic send_digit(input logic [2:0] position, input logic [7:0] ch,
			input logic dp_en);
		request_t r;
		r            = '0;
		r.op         = OP_DIGIT;
		r.position   = position;
		r.digit_char = ch;
		r.dp_en      = dp_en;
		send_request(r);
	endtask

	// stop offering and let every predicted byte drain, plus slack for a late op 0
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// back-to-back register writes starting at index 0
	task automatic write_registers(input logic [7:0] values [8], input int count);
		for (int i = 0; i < count; i++) begin
			cfg_valid <= 1'b1;
			cfg_addr  <= 3'(i);
			cfg_data  <= values[i];
			do @(negedge clk); while (!cfg_ready);
			sb.write_register(reg_index_t'(i), values[i]);
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// stimulus: directed corners, then random phases under different settings
	initial begin
		request_t    r;
		logic [7:0]  settings [8];
		int unsigned pick, mode;
		sb = new();
		burst_left = $urandom_range(0, 19);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rounding, sign, point placement and range corners
		send_number(32'h0000_0000, 3'd0);
		send_number(32'h0001_8000, 3'd0);  // 1.5 rounds up
		send_number(32'h0000_8000, 3'd0);  // 0.5 rounds up
		send_number(32'h0003_243f, 3'd4);  // pi, too wide, cut to three decimals
		send_number(32'hfff3_a7ae, 3'd3);  // -12.345, cut to one decimal
		send_number(32'h007b_74bc, 3'd3);  // 123.456
		send_number(32'h270f_7fff, 3'd2);  // just under 9999.5
		send_number(Q_TOP_BOUND, 3'd1);
		send_number(Q_BOTTOM_BOUND, 3'd0);
		send_number(32'hfc18_8001, 3'd0);  // just above -999.5
		send_number(32'hffff_cccd, 3'd0);  // -0.2 shows minus zero
		send_number(32'h7fff_ffff, 3'd2);
		send_number(32'h8000_0000, 3'd0);
		send_number(32'h0000_0001, 3'd7);  // decimals beyond four
		// raw table indexes, including past the end
		send_codes(8'd0, 8'd9, 8'd15, 8'd16);
		send_codes(8'd31, 8'd32, 8'd33, 8'd34);
		send_codes(8'd255, 8'd128, 8'd200, 8'd64);
		// single digit: letters, out of table, point wrap
		send_digit(3'd0, "A", 1'b0);
		send_digit(3'd7, "f", 1'b1);
		send_digit(3'd3, "F", 1'b0);
		send_digit(3'd5, "a", 1'b0);
		send_digit(3'd1, "G", 1'b0);
		send_digit(3'd2, 8'd255, 1'b1);
		send_digit(3'd6, 8'd33, 1'b0);
		send_digit(3'd4, "0", 1'b1);
		r    = '1;
		r.op = OP_NONE;
		send_request(r);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			quiesce();
			case (p)
				1: foreach (settings[k]) settings[k] = 8'h00;
				2: begin
					settings[0] = 8'd7;
					for (int k = 1; k < 8; k++) settings[k] = 8'hff;
				end
				4: begin
					settings[0] = {5'b0, CFG_RESET.brightness};
					settings[1] = CFG_RESET.display_on_base;
					settings[2] = CFG_RESET.auto_increment_cmd;
					settings[3] = CFG_RESET.fixed_address_cmd;
					settings[4] = CFG_RESET.start_address_cmd;
					settings[5] = CFG_RESET.set_address_cmd;
				end
				default: begin
					settings[0] = 8'($urandom_range(0, 7));
					for (int k = 1; k < 8; k++) settings[k] = 8'($urandom);
				end
			endcase
			write_registers(settings, (p == 0) ? 8 : 6);
			// the long receiver hold-off falls into this phase
			if (p == 2)
				hold_off_request = 1'b1;

			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				// unused fields carry random bits too
				r.number     = $urandom;
				r.decimals   = 3'($urandom);
				r.code_a     = 8'($urandom);
				r.code_b     = 8'($urandom);
				r.code_c     = 8'($urandom);
				r.code_d     = 8'($urandom);
				r.position   = 3'($urandom);
				r.digit_char = 8'($urandom);
				r.dp_en      = 1'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					r.op = OP_NUMBER;
					mode = $urandom_range(0, 9);
					case (mode)
						0: ;  // full range, mostly out of range
						1, 2, 3: r.number = $urandom_range(0, 32'd655360000);
						4: r.number = -$urandom_range(0, 32'd65536000);
						5, 6: r.number = $urandom_range(0, 32'd13107200);
						7: r.number = $urandom_range(0, 32'd131072);
						8: begin
							case ($urandom_range(0, 3))
								0: r.number = Q_TOP_BOUND;
								1: r.number = Q_BOTTOM_BOUND;
								2: r.number = Q_NEAR_1000;
								default: r.number = Q_NEAR_100;
							endcase
							r.number = r.number + $urandom_range(0, 6) - 3;
						end
						default: r.number = ($urandom_range(0, 9999) << 16) | 32'h8000;
					endcase
					if (mode >= 5 && mode != 8 && $urandom_range(0, 1) == 1)
						r.number = -r.number;
					r.decimals = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
						: 3'($urandom_range(0, 4));
				end else if (pick < 65) begin
					r.op = OP_CODES;
					if ($urandom_range(0, 1) == 1) r.code_a = 8'($urandom_range(0, 33));
					if ($urandom_range(0, 1) == 1) r.code_b = 8'($urandom_range(0, 33));
					if ($urandom_range(0, 1) == 1) r.code_c = 8'($urandom_range(0, 33));
					if ($urandom_range(0, 1) == 1) r.code_d = 8'($urandom_range(0, 33));
				end else if (pick < 95) begin
					r.op = OP_DIGIT;
					case ($urandom_range(0, 3))
						0: r.digit_char = "A" + 8'($urandom_range(0, 5));
						1: r.digit_char = "a" + 8'($urandom_range(0, 5));
						2: r.digit_char = 8'($urandom_range(0, 33));
						default: ;
					endcase
				end else
					r.op = OP_NONE;
				send_request(r);
			end
		end

		quiesce();
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// receiver: stall pattern changes per stretch, one long hold-off on request
	initial begin
		int unsigned mode, span;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			for (int k = 0; k < span; k++) begin
				@(posedge clk);
				if (hold_off_request && !hold_off_done) begin
					m_axis_tready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
					hold_off_done = 1'b1;
				end else
					case (mode)
						0: m_axis_tready <= 1'b1;
						1: m_axis_tready <= 1'($urandom_range(0, 1));
						2: m_axis_tready <= ($urandom_range(0, 3) == 0);
						default: m_axis_tready <= (k % 3 != 0);
					endcase
			end
		end
	end

	// output check and watchdog, sampled mid-cycle when all signals are settled
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_byte('{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast});
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end
endmodule
